/* hdl/bclru_pkg.sv */
// shared types, constants and helpers of the block cache lru controller
// used by bclru_ctrl, bclru_dp and block_cache_lru_controller; depends on nothing
package bclru_pkg;

	// cache geometry
	localparam int Slots     = 16;
	localparam int SlotBits  = $clog2(Slots);
	localparam int AgeBits   = 32;
	localparam int BlockBits = 32;

	// fixed field widths
	localparam int AddrBits    = 32;
	localparam int MaskBits    = 16;
	localparam int SlotOutBits = 4;
	localparam int InDataBits  = 56;
	localparam int OutDataBits = 48;

	// configuration port
	localparam int CfgAddrBits  = 3;
	localparam int CfgDataBits  = 32;
	localparam int CfgIndexBits = CfgAddrBits - 2;
	localparam logic [CfgIndexBits-1:0] RegTotalBlocks = CfgIndexBits'(0);

	// request kinds
	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_SWITCH = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_WB_FAIL   = 2'd2,
		ST_FILL_FAIL = 2'd3
	} status_t;

	// which result the datapath builds
	typedef enum logic [2:0] {
		RES_RANGE    = 3'd0,
		RES_HIT      = 3'd1,
		RES_WB_FAIL  = 3'd2,
		RES_MISS     = 3'd3,
		RES_FLUSH    = 3'd4,
		RES_NO_FLUSH = 3'd5
	} res_kind_t;

	// one input item
	typedef struct packed {
		op_t                 op;
		logic [AddrBits-1:0] block_addr;
		logic [MaskBits-1:0] write_fail_mask;
		logic                read_ok;
		logic                drive_select;
	} req_t;

	// one result item
	typedef struct packed {
		status_t                status;
		logic                   hit;
		logic [SlotOutBits-1:0] slot;
		logic                   writeback_valid;
		logic [SlotOutBits-1:0] writeback_slot;
		logic [AddrBits-1:0]    writeback_block;
		logic                   fill_valid;
		logic                   target_drive;
		logic                   last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      hit_upd;
		logic      scan_start;
		logic      scan_step;
		logic      miss_upd;
		logic      flush_step;
		logic      clear_all;
		logic      sel_victim;
		logic      emit;
		res_kind_t kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic in_range;
		logic hit;
		logic victim_fail;
		logic cur_dirty;
		logic idx_last;
		logic flush_any;
		logic out_free;
	} dp_stat_t;

	// write-back of a slot fails; slots past the mask always succeed
	function automatic logic wb_fails(logic [MaskBits-1:0] mask, logic [SlotBits-1:0] slot);
		logic [MaskBits-1:0] sh;
		sh = mask >> slot;
		return sh[0];
	endfunction

endpackage

/* hdl/bclru_ctrl.sv */
// request sequencer of the block cache lru controller
// depends on bclru_pkg; drives bclru_dp through dp_cmd_t and reads dp_stat_t
module bclru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bclru_pkg::dp_stat_t stat,
	output bclru_pkg::dp_cmd_t  cmd
);
	import bclru_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_SCAN   = 6'b000100,
		S_MISS   = 6'b001000,
		S_FLUSH  = 6'b010000,
		S_FEND   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		cmd       = '0;
		cmd.kind  = RES_RANGE;
		state_nxt = state_q;
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.op == OP_FLUSH || stat.op == OP_SWITCH) begin
					state_nxt = S_FLUSH;
				end else if (!stat.in_range) begin
					if (stat.out_free) begin
						cmd.emit  = 1'b1;
						cmd.kind  = RES_RANGE;
						state_nxt = S_IDLE;
					end
				end else if (stat.hit) begin
					if (stat.out_free) begin
						cmd.emit    = 1'b1;
						cmd.kind    = RES_HIT;
						cmd.hit_upd = 1'b1;
						state_nxt   = S_IDLE;
					end
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.idx_last) begin
					state_nxt = S_MISS;
				end
			end
			S_MISS: begin
				cmd.sel_victim = 1'b1;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.victim_fail) begin
						cmd.kind = RES_WB_FAIL;
					end else begin
						cmd.kind     = RES_MISS;
						cmd.miss_upd = 1'b1;
					end
					state_nxt = S_IDLE;
				end
			end
			S_FLUSH: begin
				// one slot per cycle, stalling only on a dirty slot
				if (!stat.cur_dirty || stat.out_free) begin
					cmd.flush_step = 1'b1;
					cmd.emit       = stat.cur_dirty;
					cmd.kind       = RES_FLUSH;
					if (stat.idx_last) begin
						state_nxt = S_FEND;
					end
				end
			end
			S_FEND: begin
				if (stat.flush_any || stat.out_free) begin
					cmd.emit      = !stat.flush_any;
					cmd.kind      = RES_NO_FLUSH;
					cmd.clear_all = (stat.op == OP_SWITCH);
					state_nxt     = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/bclru_dp.sv */
// tag, valid, dirty and age state with the result register
// depends on bclru_pkg; commanded by bclru_ctrl
module bclru_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bclru_pkg::dp_cmd_t            cmd,
	output bclru_pkg::dp_stat_t           stat,
	input  bclru_pkg::req_t               req,
	input  logic [bclru_pkg::AddrBits-1:0] total_blocks,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output bclru_pkg::result_t            result
);
	import bclru_pkg::*;

	// cache state
	logic [BlockBits-1:0] tag_q [Slots];
	logic [Slots-1:0]     valid_q;
	logic [Slots-1:0]     dirty_q;
	logic [AgeBits-1:0]   age_q [Slots];
	logic [AgeBits-1:0]   counter_q;
	logic                 drive_q;

	// request and scan registers
	req_t                req_q;
	logic [SlotBits-1:0] idx_q;
	logic [SlotBits-1:0] victim_q;
	logic [AgeBits-1:0]  min_q;
	logic                flush_any_q;

	// result register
	result_t out_q;
	logic    out_valid_q;

	logic [BlockBits-1:0] req_tag;
	logic [Slots-1:0]     match;
	logic [Slots-1:0]     vd;
	logic [Slots-1:0]     vd_above;
	logic [Slots-1:0]     valid_left;
	logic [SlotBits-1:0]  hit_slot;
	logic [SlotBits-1:0]  free_slot;
	logic [SlotBits-1:0]  rd_slot;
	logic [BlockBits-1:0] tag_rd;
	logic [AgeBits-1:0]   age_rd;
	logic                 victim_vd;
	logic                 cur_fail;
	logic                 fill_fail;
	result_t              res;

	assign req_tag = BlockBits'(req_q.block_addr);
	assign vd      = valid_q & dirty_q;

	// tag match on every slot, first match wins
	always_comb begin
		hit_slot = '0;
		for (int i = Slots - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (tag_q[i] == req_tag);
			if (match[i]) begin
				hit_slot = SlotBits'(i);
			end
		end
	end

	// first invalid slot once the victim has been dropped
	always_comb begin
		valid_left = valid_q & ~(Slots'(1) << victim_q);
		free_slot  = '0;
		for (int i = Slots - 1; i >= 0; i--) begin
			if (!valid_left[i]) begin
				free_slot = SlotBits'(i);
			end
		end
	end

	// single tag read port and the age read of the scan
	assign rd_slot   = cmd.sel_victim ? victim_q : idx_q;
	assign tag_rd    = tag_q[rd_slot];
	assign age_rd    = age_q[idx_q];
	assign victim_vd = vd[victim_q];
	assign cur_fail  = wb_fails(req_q.write_fail_mask, idx_q);
	assign fill_fail = (req_q.op == OP_READ) && !req_q.read_ok;
	assign vd_above  = vd >> idx_q;

	// status to the controller
	always_comb begin
		stat.op          = req_q.op;
		stat.in_range    = (req_q.block_addr < total_blocks) &&
			((req_q.block_addr >> BlockBits) == '0);
		stat.hit         = |match;
		stat.victim_fail = victim_vd && wb_fails(req_q.write_fail_mask, victim_q);
		stat.cur_dirty   = vd[idx_q];
		stat.idx_last    = (idx_q == SlotBits'(Slots - 1));
		stat.flush_any   = flush_any_q;
		stat.out_free    = !out_valid_q || m_tready;
	end

	// result item build
	always_comb begin
		res              = '0;
		res.status       = ST_OK;
		res.target_drive = drive_q;
		res.last         = 1'b1;
		case (cmd.kind)
			RES_RANGE: begin
				res.status = ST_RANGE;
			end
			RES_HIT: begin
				res.hit  = 1'b1;
				res.slot = SlotOutBits'(hit_slot);
			end
			RES_WB_FAIL: begin
				res.status          = ST_WB_FAIL;
				res.slot            = SlotOutBits'(victim_q);
				res.writeback_valid = 1'b1;
				res.writeback_slot  = SlotOutBits'(victim_q);
				res.writeback_block = AddrBits'(tag_rd);
			end
			RES_MISS: begin
				res.status     = fill_fail ? ST_FILL_FAIL : ST_OK;
				res.slot       = SlotOutBits'(free_slot);
				res.fill_valid = (req_q.op == OP_READ);
				if (victim_vd) begin
					res.writeback_valid = 1'b1;
					res.writeback_slot  = SlotOutBits'(victim_q);
					res.writeback_block = AddrBits'(tag_rd);
				end
			end
			RES_FLUSH: begin
				res.status          = cur_fail ? ST_WB_FAIL : ST_OK;
				res.slot            = SlotOutBits'(idx_q);
				res.writeback_valid = 1'b1;
				res.writeback_slot  = SlotOutBits'(idx_q);
				res.writeback_block = AddrBits'(tag_rd);
				res.last            = ~|vd_above[Slots-1:1];
			end
			RES_NO_FLUSH: begin
				res.last = 1'b1;
			end
			default: begin
				res.last = 1'b1;
			end
		endcase
	end

	// control state: valid, dirty, ages, counter, drive, scan index, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			age_q       <= '{default: '0};
			counter_q   <= '0;
			drive_q     <= 1'b0;
			idx_q       <= '0;
			victim_q    <= '0;
			flush_any_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q       <= '0;
				flush_any_q <= 1'b0;
			end
			// hit refreshes the stamp
			if (cmd.hit_upd) begin
				age_q[hit_slot] <= counter_q;
				counter_q       <= counter_q + AgeBits'(1);
				if (req_q.op == OP_WRITE) begin
					dirty_q[hit_slot] <= 1'b1;
				end
			end
			// least stamp search, one slot a cycle
			if (cmd.scan_start) begin
				victim_q <= '0;
				idx_q    <= SlotBits'(1);
			end
			if (cmd.scan_step) begin
				if (age_rd < min_q) begin
					victim_q <= idx_q;
				end
				idx_q <= idx_q + SlotBits'(1);
			end
			// miss: drop the victim, then fill the first free slot
			if (cmd.miss_upd) begin
				if (victim_vd) begin
					dirty_q[victim_q] <= 1'b0;
				end
				valid_q[victim_q]  <= 1'b0;
				valid_q[free_slot] <= !fill_fail;
				dirty_q[free_slot] <= (req_q.op == OP_WRITE);
				age_q[free_slot]   <= counter_q;
				counter_q          <= counter_q + AgeBits'(1);
			end
			// flush walk
			if (cmd.flush_step) begin
				idx_q <= idx_q + SlotBits'(1);
				if (cmd.emit) begin
					flush_any_q <= 1'b1;
					if (!cur_fail) begin
						dirty_q[idx_q] <= 1'b0;
					end
				end
			end
			// drive switch clears every slot
			if (cmd.clear_all) begin
				valid_q <= '0;
				dirty_q <= '0;
				age_q   <= '{default: '0};
				drive_q <= req_q.drive_select;
			end
			// output register
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.scan_start) begin
			min_q <= age_q[0];
		end
		if (cmd.scan_step && (age_rd < min_q)) begin
			min_q <= age_rd;
		end
		if (cmd.miss_upd) begin
			tag_q[free_slot] <= req_tag;
		end
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign result   = out_q;

endmodule

/* hdl/block_cache_lru_controller.sv */
// Block cache lru controller: tag, valid, dirty and age bookkeeping for a
// fully associative write-back cache of bclru_pkg::Slots slots. One request
// is handled at a time; the next item is taken once the previous request has
// placed its last result in the output register. Out-of-range requests and
// hits load their result from the decode state that follows acceptance.
// A miss walks the age stamps one slot per cycle to find the least recent
// slot, then loads its result before the next item can be taken. A flush or
// drive switch visits one slot per cycle, holding on a dirty slot while the
// output register is full, and then closes out. Any request also waits
// while the output register still holds an item that was not taken. There is
// no clearing pass after reset. total_blocks sits at byte address 0 of the
// configuration port and resets to zero, which rejects every read and write
// until it is set.
// depends on bclru_pkg, bclru_ctrl and bclru_dp
module block_cache_lru_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	// request stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// block_addr[31:0], write_fail_mask[47:32], read_ok[48], drive_select[49]
	input  logic [bclru_pkg::InDataBits-1:0]    s_tdata,
	// op[1:0]
	input  logic [1:0]                          s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status[1:0], hit[2], slot[6:3], writeback_valid[7], writeback_slot[11:8],
	// writeback_block[43:12], fill_valid[44], target_drive[45]
	output logic [bclru_pkg::OutDataBits-1:0]   m_tdata,
	output logic                                m_tlast,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bclru_pkg::CfgAddrBits-1:0]   paddr,
	input  logic [bclru_pkg::CfgDataBits-1:0]   pwdata,
	output logic [bclru_pkg::CfgDataBits-1:0]   prdata,
	output logic                                pready
);
	import bclru_pkg::*;

	logic [AddrBits-1:0]     total_blocks_q;
	logic [CfgIndexBits-1:0] cfg_index;
	req_t                    req;
	result_t                 result;
	dp_cmd_t                 cmd;
	dp_stat_t                stat;

	// register file
	assign pready    = 1'b1;
	assign cfg_index = paddr[CfgAddrBits-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= '0;
		end else if (psel && penable && pwrite && pready && cfg_index == RegTotalBlocks) begin
			total_blocks_q <= AddrBits'(pwdata);
		end
	end

	assign prdata = (cfg_index == RegTotalBlocks) ? CfgDataBits'(total_blocks_q) : '0;

	// unpack the request item
	always_comb begin
		req.op              = op_t'(s_tuser);
		req.block_addr      = s_tdata[AddrBits-1:0];
		req.write_fail_mask = s_tdata[AddrBits+MaskBits-1:AddrBits];
		req.read_ok         = s_tdata[AddrBits+MaskBits];
		req.drive_select    = s_tdata[AddrBits+MaskBits+1];
	end

	bclru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bclru_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req          (req),
		.total_blocks (total_blocks_q),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.result       (result)
	);

	// pack the result item
	assign m_tdata = {2'b00, result.target_drive, result.fill_valid, result.writeback_block,
		result.writeback_slot, result.writeback_valid, result.slot, result.hit,
		result.status};
	assign m_tlast = result.last;

endmodule
